// ===== hw/rtl/prr_pkg.sv =====
// ----------------------------------------------------------------------------
// prr_pkg
// Shared types and constants of the priority provider registry: operation and
// status codes, the command and result words, and the control groups passed
// between the sequencer, the slot store and the scan unit.
// ----------------------------------------------------------------------------
package prr_pkg;

  localparam int ID_BITS        = 16;
  localparam int NAME_BITS      = 16;
  localparam int PRIO_IN_BITS   = 16;
  localparam int COUNT_OUT_BITS = 4;
  localparam int ORDER_BITS     = 32;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_QUERY      = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]                     opcode;
    logic [ID_BITS-1:0]             provider_id;
    logic [NAME_BITS-1:0]           name_tag;
    logic signed [PRIO_IN_BITS-1:0] priority_in;
  } in_word_t;

  typedef struct packed {
    status_t                        status;
    logic [COUNT_OUT_BITS-1:0]      entry_count;
    logic [ID_BITS-1:0]             active_id;
    logic [NAME_BITS-1:0]           lead_name;
    logic signed [PRIO_IN_BITS-1:0] lead_priority;
  } out_word_t;

  // Write controls for one slot of the store.
  typedef struct packed {
    logic set_valid;
    logic clear_valid;
    logic wr_ident;   // key and order stamp
    logic wr_meta;    // name and priority
  } wr_ctl_t;

  // What the scan over all slots has found.
  typedef struct packed {
    logic match_found;
    logic free_found;
    logic best_found;
  } scan_flags_t;

endpackage

// ===== hw/rtl/prr_slot_store.sv =====
// ----------------------------------------------------------------------------
// prr_slot_store
// Slot table: valid bits in flops, slot fields in memories with one write
// port and one registered read port.
// ----------------------------------------------------------------------------
module prr_slot_store
  import prr_pkg::*;
#(
  parameter int SLOTS = 8,
  parameter int AW    = 3,
  parameter int KW    = 16,
  parameter int PW    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  wr_ctl_t               wr_ctl,
  input  logic [AW-1:0]         wr_addr,
  input  logic [KW-1:0]         wr_key,
  input  logic [NAME_BITS-1:0]  wr_name,
  input  logic signed [PW-1:0]  wr_prio,
  input  logic [ORDER_BITS-1:0] wr_order,
  input  logic [AW-1:0]         rd_addr,
  output logic                  rd_valid,
  output logic [KW-1:0]         rd_key,
  output logic [NAME_BITS-1:0]  rd_name,
  output logic signed [PW-1:0]  rd_prio,
  output logic [ORDER_BITS-1:0] rd_order
);

  logic [SLOTS-1:0]      valid;
  logic [KW-1:0]         key_mem   [SLOTS];
  logic [NAME_BITS-1:0]  name_mem  [SLOTS];
  logic [PW-1:0]         prio_mem  [SLOTS];
  logic [ORDER_BITS-1:0] order_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_ctl.set_valid) begin
      valid[wr_addr] <= 1'b1;
    end else if (wr_ctl.clear_valid) begin
      valid[wr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ctl.wr_ident) begin
      key_mem[wr_addr]   <= wr_key;
      order_mem[wr_addr] <= wr_order;
    end
    if (wr_ctl.wr_meta) begin
      name_mem[wr_addr] <= wr_name;
      prio_mem[wr_addr] <= wr_prio;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= valid[rd_addr];
    rd_key   <= key_mem[rd_addr];
    rd_name  <= name_mem[rd_addr];
    rd_prio  <= prio_mem[rd_addr];
    rd_order <= order_mem[rd_addr];
  end

endmodule

// ===== hw/rtl/prr_scan_unit.sv =====
// ----------------------------------------------------------------------------
// prr_scan_unit
// Compare unit applied to one slot per step: tracks the first key match, the
// first free slot and the best entry so far.
// ----------------------------------------------------------------------------
module prr_scan_unit
  import prr_pkg::*;
#(
  parameter int AW = 3,
  parameter int KW = 16,
  parameter int PW = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  step,
  input  logic [AW-1:0]         step_idx,
  input  logic [KW-1:0]         cmd_key,
  input  logic                  rd_valid,
  input  logic [KW-1:0]         rd_key,
  input  logic [NAME_BITS-1:0]  rd_name,
  input  logic signed [PW-1:0]  rd_prio,
  input  logic [ORDER_BITS-1:0] rd_order,
  output scan_flags_t           flags,
  output logic [AW-1:0]         match_idx,
  output logic [AW-1:0]         free_idx,
  output logic [KW-1:0]         best_key,
  output logic [NAME_BITS-1:0]  best_name,
  output logic signed [PW-1:0]  best_prio
);

  logic [ORDER_BITS-1:0] best_order;
  logic                  better;
  logic                  is_match;

  // Higher priority wins; on equal priority the smaller order stamp wins.
  assign better = rd_valid &&
                  (!flags.best_found || (rd_prio > best_prio) ||
                   ((rd_prio == best_prio) && (rd_order < best_order)));
  assign is_match = rd_valid && (rd_key == cmd_key);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      flags <= '0;
    end else if (step) begin
      if (!flags.match_found && is_match) begin
        flags.match_found <= 1'b1;
        match_idx         <= step_idx;
      end
      if (!flags.free_found && !rd_valid) begin
        flags.free_found <= 1'b1;
        free_idx         <= step_idx;
      end
      if (better) begin
        flags.best_found <= 1'b1;
        best_key         <= rd_key;
        best_name        <= rd_name;
        best_prio        <= rd_prio;
        best_order       <= rd_order;
      end
    end
  end

endmodule

// ===== hw/rtl/priority_provider_registry.sv =====
// ----------------------------------------------------------------------------
// priority_provider_registry
// Table of provider slots keyed by provider identifier, with register,
// unregister and query-active operations.
// ----------------------------------------------------------------------------
// Each command runs a scan over every slot, then the drain state and the
// commit state, before busy drops again; the result word appears on result
// with done high for exactly one cycle, the cycle in which busy is low
// again, and it is not held, so the receiver must take it then. The slot
// store is walked one slot per cycle through its single read port by one
// shared compare unit; the drain state waits for the registered read of the
// last slot and the commit state updates the table. A new command may be
// issued in the same cycle that done is shown, but not while busy is high.
module priority_provider_registry
  import prr_pkg::*;
#(
  parameter int SLOTS         = 8,
  parameter int KEY_BITS      = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  command,
  output logic      done,
  output out_word_t result
);

  // Slot index width, stored key width and stored priority width. Keys and
  // priorities never need more bits than the 16-bit fields carry.
  localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KW   = (KEY_BITS < ID_BITS) ? KEY_BITS : ID_BITS;
  localparam int PW   = (PRIORITY_BITS < PRIO_IN_BITS) ? PRIORITY_BITS : PRIO_IN_BITS;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int PMAX = (1 << (PW - 1)) - 1;
  localparam int PMIN = -PMAX - 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

  // The sequencer walks the slots, waits for the last read, then commits.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t                state;
  in_word_t              cmd;
  logic [AW-1:0]         idx;
  logic                  eval;
  logic [AW-1:0]         eval_idx;
  logic [CW-1:0]         used_count;
  logic [ORDER_BITS-1:0] next_order;

  logic                  accept;
  logic [KW-1:0]         cmd_key;
  logic signed [PW-1:0]  prio_sat;

  // Store and scan unit connections.
  wr_ctl_t               wr_ctl;
  wr_ctl_t               commit_ctl;
  logic [AW-1:0]         wr_addr;
  logic                  rd_valid;
  logic [KW-1:0]         rd_key;
  logic [NAME_BITS-1:0]  rd_name;
  logic signed [PW-1:0]  rd_prio;
  logic [ORDER_BITS-1:0] rd_order;
  scan_flags_t           flags;
  logic [AW-1:0]         match_idx;
  logic [AW-1:0]         free_idx;
  logic [KW-1:0]         best_key;
  logic [NAME_BITS-1:0]  best_name;
  logic signed [PW-1:0]  best_prio;

  // Commit results.
  status_t               status;
  logic [CW-1:0]         count_next;
  logic [ORDER_BITS-1:0] order_next;
  logic [CW+3:0]         count_wide;
  out_word_t             result_next;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign cmd_key = cmd.provider_id[KW-1:0];

  // Clamp the incoming priority to the signed range of the stored width.
  always_comb begin
    if (int'(cmd.priority_in) > PMAX) begin
      prio_sat = PW'(PMAX);
    end else if (int'(cmd.priority_in) < PMIN) begin
      prio_sat = PW'(PMIN);
    end else begin
      prio_sat = PW'(cmd.priority_in);
    end
  end

  // Decide the outcome of the command once the scan has seen every slot.
  always_comb begin
    wr_ctl      = '0;
    wr_addr     = match_idx;
    status      = ST_OK;
    count_next  = used_count;
    order_next  = next_order;
    result_next = '0;
    unique case (cmd.opcode)
      OP_REGISTER: begin
        if ((cmd_key == '0) || (cmd.name_tag == '0)) begin
          status = ST_INVALID;
        end else if (flags.match_found) begin
          // Known key: only name and priority change.
          wr_ctl.wr_meta = 1'b1;
        end else if (flags.free_found) begin
          wr_addr          = free_idx;
          wr_ctl.set_valid = 1'b1;
          wr_ctl.wr_ident  = 1'b1;
          wr_ctl.wr_meta   = 1'b1;
          order_next       = next_order + 1'b1;
          count_next       = used_count + 1'b1;
        end else begin
          status = ST_FULL;
        end
      end
      OP_UNREGISTER: begin
        if (cmd_key == '0) begin
          status = ST_INVALID;
        end else if (flags.match_found) begin
          wr_ctl.clear_valid = 1'b1;
          if (used_count != '0) begin
            count_next = used_count - 1'b1;
          end
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      OP_QUERY: begin
        if (flags.best_found) begin
          result_next.active_id     = ID_BITS'(best_key);
          result_next.lead_name     = best_name;
          result_next.lead_priority = PRIO_IN_BITS'(best_prio);
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      default: begin
        status = ST_INVALID;
      end
    endcase
    count_wide              = {4'd0, count_next};
    result_next.status      = status;
    result_next.entry_count = count_wide[COUNT_OUT_BITS-1:0];
  end

  assign commit_ctl = (state == S_COMMIT) ? wr_ctl : '0;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      eval       <= 1'b0;
      done       <= 1'b0;
      used_count <= '0;
      next_order <= ORDER_BITS'(1);
    end else begin
      done     <= 1'b0;
      eval     <= (state == S_SCAN);
      eval_idx <= idx;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd   <= command;
            idx   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          used_count <= count_next;
          next_order <= order_next;
          result     <= result_next;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  prr_slot_store #(
    .SLOTS (SLOTS),
    .AW    (AW),
    .KW    (KW),
    .PW    (PW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_ctl   (commit_ctl),
    .wr_addr  (wr_addr),
    .wr_key   (cmd_key),
    .wr_name  (cmd.name_tag),
    .wr_prio  (prio_sat),
    .wr_order (next_order),
    .rd_addr  (idx),
    .rd_valid (rd_valid),
    .rd_key   (rd_key),
    .rd_name  (rd_name),
    .rd_prio  (rd_prio),
    .rd_order (rd_order)
  );

  prr_scan_unit #(
    .AW (AW),
    .KW (KW),
    .PW (PW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .clear     (accept),
    .step      (eval),
    .step_idx  (eval_idx),
    .cmd_key   (cmd_key),
    .rd_valid  (rd_valid),
    .rd_key    (rd_key),
    .rd_name   (rd_name),
    .rd_prio   (rd_prio),
    .rd_order  (rd_order),
    .flags     (flags),
    .match_idx (match_idx),
    .free_idx  (free_idx),
    .best_key  (best_key),
    .best_name (best_name),
    .best_prio (best_prio)
  );

endmodule

// ===== hw/rtl/prr_checker.sv =====
// ----------------------------------------------------------------------------
// prr_checker
// Port-level checks of the registry's command and result timing, bound to the
// top level.
// ----------------------------------------------------------------------------
module prr_checker
  import prr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input out_word_t result
);

  // A result is only shown once the block has finished its command.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // An accepted command keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a command");

  // Each command gives a single one-cycle result.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // Only a successful query reports an active provider.
  a_active_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != ST_OK)) |->
      ((result.active_id == '0) && (result.lead_name == '0) &&
       (result.lead_priority == '0)))
    else $error("active entry reported on a failed operation");

endmodule

bind priority_provider_registry prr_checker u_prr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== bench/priority_provider_registry_checker.sv =====
// ----------------------------------------------------------------------------
// priority_provider_registry_checker
// Watches the command and result channels of the registry, keeps its own copy
// of the provider table, predicts the result word of every accepted command,
// and compares each result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module priority_provider_registry_checker
  import prr_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  command,
  input  logic      done,
  input  out_word_t result,
  output int        mismatch_count,
  output int        words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                            tbl_valid [SLOTS];
  logic [ID_BITS-1:0]              tbl_key   [SLOTS];
  logic [NAME_BITS-1:0]            tbl_name  [SLOTS];
  logic signed [PRIO_IN_BITS-1:0]  tbl_prio  [SLOTS];
  logic [ORDER_BITS-1:0]           tbl_stamp [SLOTS];
  logic [ORDER_BITS-1:0]           stamp_next;
  logic [COUNT_OUT_BITS-1:0]       tbl_count;

  out_word_t registry_replies [$];

  // Applies one command to the table copy and returns the word it yields.
  function automatic out_word_t registry_apply(in_word_t w);
    out_word_t r;
    int i;
    int hit;
    int spot;
    int best;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    spot = -1;
    best = -1;
    for (i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i] && tbl_key[i] == w.provider_id && hit < 0) hit = i;
      if (!tbl_valid[i] && spot < 0) spot = i;
      if (tbl_valid[i]) begin
        if (best < 0 || tbl_prio[i] > tbl_prio[best] ||
            (tbl_prio[i] == tbl_prio[best] && tbl_stamp[i] < tbl_stamp[best])) begin
          best = i;
        end
      end
    end
    case (w.opcode)
      OP_REGISTER: begin
        if (w.provider_id == '0 || w.name_tag == '0) begin
          r.status = ST_INVALID;
        end else if (hit >= 0) begin
          tbl_name[hit] = w.name_tag;
          tbl_prio[hit] = w.priority_in;
        end else if (spot < 0) begin
          r.status = ST_FULL;
        end else begin
          tbl_valid[spot] = 1'b1;
          tbl_key[spot]   = w.provider_id;
          tbl_name[spot]  = w.name_tag;
          tbl_prio[spot]  = w.priority_in;
          tbl_stamp[spot] = stamp_next;
          stamp_next      = stamp_next + 1;
          tbl_count       = tbl_count + 1;
        end
      end
      OP_UNREGISTER: begin
        if (w.provider_id == '0) begin
          r.status = ST_INVALID;
        end else if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          tbl_valid[hit] = 1'b0;
          tbl_key[hit]   = '0;
          tbl_name[hit]  = '0;
          tbl_prio[hit]  = '0;
          tbl_stamp[hit] = '0;
          if (tbl_count != 0) tbl_count = tbl_count - 1;
        end
      end
      OP_QUERY: begin
        if (best < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.active_id     = tbl_key[best];
          r.lead_name     = tbl_name[best];
          r.lead_priority = tbl_prio[best];
        end
      end
      default: begin
        r.status = ST_INVALID;
      end
    endcase
    r.entry_count = tbl_count;
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_key[i]   = '0;
        tbl_name[i]  = '0;
        tbl_prio[i]  = '0;
        tbl_stamp[i] = '0;
      end
      stamp_next = 1;
      tbl_count = '0;
      registry_replies.delete();
      mismatch_count = 0;
    end else begin
      // The word shown now belongs to an earlier command, so it is checked
      // before a command accepted at this same edge is predicted.
      if (done === 1'b1) begin
        if (registry_replies.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result word with none expected, expected no word, actual %h",
                   $time, result);
        end else begin
          want = registry_replies.pop_front();
          flag_field("status", 32'(want.status), 32'(result.status));
          flag_field("entry_count", 32'(want.entry_count), 32'(result.entry_count));
          flag_field("active_id", 32'(want.active_id), 32'(result.active_id));
          flag_field("lead_name", 32'(want.lead_name), 32'(result.lead_name));
          flag_field("lead_priority", 32'(want.lead_priority),
                     32'(result.lead_priority));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        registry_replies.push_back(registry_apply(command));
      end
    end
    words_pending = registry_replies.size();
  end

endmodule

// ===== bench/priority_provider_registry_tb.sv =====
// ----------------------------------------------------------------------------
// priority_provider_registry_tb
// Drives register, unregister and query commands into the provider registry,
// first a directed set covering null arguments, full and empty tables, ties
// and extreme priorities, then random traffic over a small pool of keys so
// that updates, table-full and not-found cases recur. A checker module beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module priority_provider_registry_tb
  import prr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode three has no operation behind it and must be rejected.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int POOL_SIZE    = 10;
  localparam int RANDOM_WORDS = 1050;
  localparam int TIMEOUT_NS   = 1_000_000;

  logic      clk = 1'b0;
  logic      rst;
  logic      start;
  logic      busy;
  in_word_t  command;
  logic      done;
  out_word_t result;
  int        mismatch_count;
  int        words_pending;

  // Random keys come mostly from this pool. It holds more keys than the table
  // has slots, so the table fills up, entries get updated in place, and some
  // unregisters miss.
  logic [ID_BITS-1:0] key_pool [POOL_SIZE];

  always #1 clk = ~clk;

  priority_provider_registry u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .command(command),
    .done   (done),
    .result (result)
  );

  priority_provider_registry_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .done          (done),
    .result        (result),
    .mismatch_count(mismatch_count),
    .words_pending (words_pending)
  );

  function automatic in_word_t make_word(input logic [1:0] op, input logic [15:0] id,
                                         input logic [15:0] name,
                                         input logic signed [15:0] prio);
    in_word_t w;
    w.opcode      = op;
    w.provider_id = id;
    w.name_tag    = name;
    w.priority_in = prio;
    return w;
  endfunction

  // Called at a falling edge. Holds the word on the command port with start
  // high until a rising edge finds busy low, then returns at the next falling
  // edge. Start is left high, so back-to-back words need no extra step.
  task automatic send_word(input in_word_t w);
    start   <= 1'b1;
    command <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Lowers start and waits until every outstanding word has come back. At
  // least one falling edge passes, so start is never lowered and raised in
  // the same step.
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
  endtask

  initial begin
    in_word_t w;
    int n;
    int r;
    int k;
    logic quiet;

    rst     = 1'b1;
    start   = 1'b0;
    command = '0;
    for (k = 0; k < POOL_SIZE; k++) key_pool[k] = 16'($urandom_range(65535, 1));

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. An empty table answers a query with not-found, and the
    // query ignores whatever sits in its other fields.
    send_word(make_word(OP_QUERY, 16'hFFFF, 16'hFFFF, 16'sh7FFF));
    // Null key on unregister, then a key that was never registered.
    send_word(make_word(OP_UNREGISTER, 16'h0000, 16'hFFFF, 16'sh8000));
    send_word(make_word(OP_UNREGISTER, 16'h1234, 16'h0000, 16'sh0000));
    // Null key and null name on register leave the table untouched.
    send_word(make_word(OP_REGISTER, 16'h0000, 16'h0005, 16'sh0001));
    send_word(make_word(OP_REGISTER, 16'h0005, 16'h0000, 16'sh0001));
    // The unused opcode is rejected even with valid-looking fields.
    send_word(make_word(OP_UNUSED, 16'h0007, 16'h0007, 16'sh0007));
    // Extreme keys, names and priorities.
    send_word(make_word(OP_REGISTER, 16'hFFFF, 16'hFFFF, 16'sh7FFF));
    send_word(make_word(OP_REGISTER, 16'h0001, 16'h0001, 16'sh8000));
    send_word(make_word(OP_QUERY, 16'h0000, 16'h0000, 16'sh0000));
    // Equal top priority registered later loses the tie to the earlier entry.
    send_word(make_word(OP_REGISTER, 16'h0002, 16'hAAAA, 16'sh7FFF));
    send_word(make_word(OP_QUERY, 16'h0000, 16'h0000, 16'sh0000));
    // An update of an existing key changes name and priority but keeps its
    // order stamp and slot.
    send_word(make_word(OP_REGISTER, 16'hFFFF, 16'h5A5A, 16'sh8000));
    send_word(make_word(OP_QUERY, 16'h0000, 16'h0000, 16'sh0000));
    // Fill the remaining slots; the last register of the loop and the one after it find the table full.
    for (k = 3; k < 9; k++) begin
      send_word(make_word(OP_REGISTER, 16'(k), 16'(k * 16'h0101), 16'sh0000));
    end
    send_word(make_word(OP_REGISTER, 16'h5555, 16'h5555, 16'sh0000));
    // An update still works on a full table.
    send_word(make_word(OP_REGISTER, 16'h0003, 16'h1234, 16'sh7FFF));
    send_word(make_word(OP_QUERY, 16'h0000, 16'h0000, 16'sh0000));
    // Freeing the lowest slot lets the next new key take it.
    send_word(make_word(OP_UNREGISTER, 16'hFFFF, 16'h0000, 16'sh0000));
    send_word(make_word(OP_REGISTER, 16'h5555, 16'h5555, 16'sh7FFF));
    send_word(make_word(OP_QUERY, 16'h0000, 16'h0000, 16'sh0000));

    // Let the block run dry once before the random traffic starts.
    wait_drained();

    // Random part. Most commands are registers and unregisters over the key
    // pool, with priorities often in a narrow band so that ties are common.
    for (n = 0; n < RANDOM_WORDS; n++) begin
      // One long stretch runs with start never dropped.
      quiet = (n >= 300 && n < 500);
      if (n == 700) wait_drained();
      if (!quiet && $urandom_range(99) < 19) begin
        start <= 1'b0;
        repeat ($urandom_range(14, 1)) @(negedge clk);
      end

      r = $urandom_range(99);
      if (r < 45) w.opcode = OP_REGISTER;
      else if (r < 75) w.opcode = OP_UNREGISTER;
      else if (r < 95) w.opcode = OP_QUERY;
      else w.opcode = OP_UNUSED;

      r = $urandom_range(99);
      if (r < 4) w.provider_id = 16'h0000;
      else if (r < 14) w.provider_id = 16'($urandom);
      else w.provider_id = key_pool[$urandom_range(POOL_SIZE - 1)];

      if ($urandom_range(99) < 3) w.name_tag = 16'h0000;
      else w.name_tag = 16'($urandom);

      r = $urandom_range(99);
      if (r < 45) w.priority_in = 16'($urandom_range(4)) - 16'sd2;
      else if (r < 50) w.priority_in = 16'sh7FFF;
      else if (r < 55) w.priority_in = 16'sh8000;
      else w.priority_in = 16'($urandom);

      send_word(w);
    end

    // Wait for the last words, with a bound, then keep the clock running so that a
    // stray result strobe would still be caught.
    start <= 1'b0;
    k = 0;
    while (words_pending != 0 && k < 1000) begin
      @(negedge clk);
      k++;
    end
    repeat (30) @(negedge clk);

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("priority_provider_registry test passed");
    end else begin
      $display("priority_provider_registry test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #TIMEOUT_NS;
    $display("priority_provider_registry test failed");
    $finish;
  end

endmodule
